>>> hdl/pkswrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkswrl_pkg
// Types and codes shared by the rate limiter files.
// ----------------------------------------------------------------------------
package pkswrl_pkg;

    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] now_seconds;
    } t_req;

    typedef struct packed {
        logic       allowed;
        logic [1:0] status;
        logic [4:0] attempts_in_window;
    } t_res;

    localparam logic [1:0] ST_KNOWN = 2'd0;
    localparam logic [1:0] ST_NEW   = 2'd1;
    localparam logic [1:0] ST_LIMIT = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [4:0]  MAX_ATTEMPTS_RESET = 5'd10;
    localparam logic [15:0] WINDOW_RESET       = 16'd60;

    localparam logic REG_MAX_ATTEMPTS = 1'b0;
    localparam logic REG_WINDOW       = 1'b1;

endpackage

>>> hdl/pkswrl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkswrl_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module pkswrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write when enabled; the output register reads every cycle (old data on a write)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

>>> hdl/per_key_sliding_window_rate_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_key_sliding_window_rate_limiter
// Per-key sliding window log rate limiter with a table of keys.
// ----------------------------------------------------------------------------
// A request is taken when i_start is high and o_busy low; one result appears
// later on o_res with o_done high for exactly one cycle, and the receiver
// cannot stall it. A known key walks the table entries up to and including
// the match (key RAM read, then compare), then pops expired log entries
// (log RAM read, then age compare) and does one more read and compare for
// the final check, then the append when the request is allowed and the
// result state; o_done follows in the next cycle. An unknown key reads and
// compares every key in use, then one further key read sees the search end,
// then come the append and the result state. With a full table the search
// over all entries runs straight into the result state. Head and fill per
// key are stored beside the key in the key RAM; the log has a RAM of its
// own. Both are only read where written, so no clearing pass is needed
// after reset.
module per_key_sliding_window_rate_limiter #(
    parameter int TABLE_ENTRIES = 64,
    parameter int LOG_DEPTH     = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pkswrl_pkg::t_req  i_req,
    output logic              o_busy,
    output logic              o_done,
    output pkswrl_pkg::t_res  o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int KW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int HW = $clog2(LOG_DEPTH);
    localparam int FW = $clog2(LOG_DEPTH + 1);
    localparam int LW = KW + HW;
    localparam int EW = 32 + HW + FW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_KRD  = 3'd1;
    localparam logic [2:0] S_KCMP = 3'd2;
    localparam logic [2:0] S_LRD  = 3'd3;
    localparam logic [2:0] S_LCMP = 3'd4;
    localparam logic [2:0] S_APP  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [4:0]    r_max;
    logic [15:0]   r_win;
    logic [CW-1:0] r_used;
    logic [KW-1:0] r_idx;
    logic [HW-1:0] r_h;
    logic [FW-1:0] r_f;
    logic          r_new;
    pkswrl_pkg::t_req r_req;
    pkswrl_pkg::t_res r_res;
    logic          r_done;

    logic          key_we, log_we;
    logic [KW-1:0] key_addr;
    logic [LW-1:0] log_addr;
    logic [EW-1:0] key_rd, key_wd;
    logic [31:0]   log_rd, log_wd;
    logic [FW-1:0] limit;
    logic [31:0]   age;
    logic          pop;
    logic          wr_cfg;
    logic [HW-1:0] tail;

    pkswrl_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_keys (
        .i_clk(i_clk), .i_we(key_we), .i_addr(key_addr),
        .i_wdata(key_wd), .o_rdata(key_rd));

    pkswrl_ram #(.WIDTH(32), .DEPTH(1 << LW)) u_log (
        .i_clk(i_clk), .i_we(log_we), .i_addr(log_addr),
        .i_wdata(log_wd), .o_rdata(log_rd));

    // clamp limit to the log depth
    assign limit = ({27'd0, r_max} > 32'(LOG_DEPTH)) ? FW'(LOG_DEPTH) : FW'(r_max);
    assign age   = r_req.now_seconds - log_rd;
    assign tail  = HW'({1'b0, r_h} + r_f);
    assign pop   = (r_f != '0) && (age > {16'd0, r_win});

    // configuration port
    assign pready = 1'b1;
    assign wr_cfg = psel && penable && pwrite;
    always_comb begin
        case (paddr[2])
            pkswrl_pkg::REG_MAX_ATTEMPTS: prdata = {27'd0, r_max};
            pkswrl_pkg::REG_WINDOW:       prdata = {16'd0, r_win};
            default:                      prdata = 32'd0;
        endcase
    end

    // memory ports follow the state
    always_comb begin
        key_we   = 1'b0;
        log_we   = 1'b0;
        key_addr = r_idx;
        key_wd   = {r_req.source_address, r_h, r_f};
        log_addr = {r_idx, r_h};
        log_wd   = r_req.now_seconds;
        // write back head and fill of a denied request
        if (r_state == S_LCMP && !pop && r_f >= limit) begin
            key_we = 1'b1;
        end
        if (r_state == S_APP) begin
            key_we = 1'b1;
            log_we = 1'b1;
            if (r_new) begin
                key_wd   = {r_req.source_address, {HW{1'b0}}, FW'(1)};
                log_addr = {r_idx, {HW{1'b0}}};
            end else begin
                key_wd   = {r_req.source_address, r_h, FW'(r_f + 1'b1)};
                log_addr = {r_idx, tail};
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_KRD;
            S_KRD:  n_state = ({1'b0, r_idx} < CW'(r_used)) ? S_KCMP : S_OUT;
            S_KCMP: n_state = S_KRD;
            S_LRD:  n_state = S_LCMP;
            S_LCMP: n_state = S_LRD;
            S_APP:  n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_max   <= pkswrl_pkg::MAX_ATTEMPTS_RESET;
            r_win   <= pkswrl_pkg::WINDOW_RESET;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            if (wr_cfg) begin
                if (paddr[2] == pkswrl_pkg::REG_MAX_ATTEMPTS) r_max <= pwdata[4:0];
                else r_win <= pwdata[15:0];
            end
            case (r_state)
                S_IDLE: begin
                    r_req <= i_req;
                    r_idx <= '0;
                    r_new <= 1'b0;
                end
                S_KRD: begin
                    // search exhausted: new key or table full
                    if (!({1'b0, r_idx} < CW'(r_used))) begin
                        if (r_used == CW'(TABLE_ENTRIES)) begin
                            r_res <= '{1'b0, pkswrl_pkg::ST_FULL, 5'd0};
                        end else begin
                            r_new   <= 1'b1;
                            r_state <= S_APP;
                            r_res   <= '{1'b1, pkswrl_pkg::ST_NEW, 5'd1};
                        end
                    end
                end
                S_KCMP: begin
                    if (key_rd[EW-1 -: 32] == r_req.source_address) begin
                        r_h     <= key_rd[FW +: HW];
                        r_f     <= key_rd[FW-1:0];
                        r_state <= S_LRD;
                    end else if (r_idx == KW'(TABLE_ENTRIES - 1)) begin
                        // last slot of a full table missed: refuse the key
                        r_res   <= '{1'b0, pkswrl_pkg::ST_FULL, 5'd0};
                        r_state <= S_OUT;
                    end else begin
                        r_idx <= KW'({1'b0, r_idx} + 1'b1);
                    end
                end
                S_LCMP: begin
                    // pop expired oldest entry, else decide
                    if (pop) begin
                        r_h <= HW'({1'b0, r_h} + 1'b1);
                        r_f <= r_f - 1'b1;
                    end else begin
                        if (r_f >= limit) begin
                            r_res   <= '{1'b0, pkswrl_pkg::ST_LIMIT, 5'(r_f)};
                            r_state <= S_OUT;
                        end else begin
                            r_res   <= '{1'b1, pkswrl_pkg::ST_KNOWN, 5'(r_f + 1'b1)};
                            r_state <= S_APP;
                        end
                    end
                end
                S_APP: begin
                    if (r_new) begin
                        r_used <= r_used + 1'b1;
                    end
                end
                S_OUT: r_done <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> dv/per_key_sliding_window_rate_limiter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_key_sliding_window_rate_limiter_tb
// Self-checking bench for the per-key sliding window rate limiter: requests
// are queued by an initial block, sent by a clocked driver with random gaps,
// and every result is checked against an in-bench model of the key table
// and the per-key attempt logs.
// ----------------------------------------------------------------------------
module per_key_sliding_window_rate_limiter_tb;

    localparam int KEYS  = 64;
    localparam int DEPTH = 16;
    localparam int DRAIN = 2 * KEYS + 4 * DEPTH + 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    pkswrl_pkg::t_req i_req = '0;
    logic        o_busy, o_done;
    pkswrl_pkg::t_res o_res;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    per_key_sliding_window_rate_limiter dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Limiter model state
    logic [4:0]  lim_max;
    logic [15:0] lim_win;
    logic [31:0] key_tab [KEYS];
    int          key_cnt;
    logic [31:0] stamp_log [KEYS][DEPTH];
    int          head_of [KEYS];
    int          fill_of [KEYS];

    pkswrl_pkg::t_req req_pending [$];
    pkswrl_pkg::t_res verdicts_due [$];
    int   errors = 0;
    int   sent = 0;
    int   checked = 0;
    int   gap = 0;
    logic o_busy_q = 1'b1;

    function automatic pkswrl_pkg::t_res judge_request(pkswrl_pkg::t_req r);
        pkswrl_pkg::t_res res;
        int lim;
        int slot;
        int hd;
        int fl;
        lim = (lim_max > DEPTH) ? DEPTH : lim_max;
        slot = -1;
        for (int k = 0; k < key_cnt; k++)
            if (slot < 0 && key_tab[k] == r.source_address) slot = k;
        if (slot >= 0) begin
            hd = head_of[slot];
            fl = fill_of[slot];
            while (fl > 0 && (r.now_seconds - stamp_log[slot][hd]) > {16'd0, lim_win}) begin
                hd = (hd + 1) % DEPTH;
                fl--;
            end
            head_of[slot] = hd;
            if (fl >= lim) begin
                fill_of[slot] = fl;
                res = '{1'b0, pkswrl_pkg::ST_LIMIT, 5'(fl)};
            end else begin
                stamp_log[slot][(hd + fl) % DEPTH] = r.now_seconds;
                fill_of[slot] = fl + 1;
                res = '{1'b1, pkswrl_pkg::ST_KNOWN, 5'(fl + 1)};
            end
        end else if (key_cnt >= KEYS) begin
            res = '{1'b0, pkswrl_pkg::ST_FULL, 5'd0};
        end else begin
            key_tab[key_cnt] = r.source_address;
            head_of[key_cnt] = 0;
            fill_of[key_cnt] = 1;
            stamp_log[key_cnt][0] = r.now_seconds;
            key_cnt++;
            res = '{1'b1, pkswrl_pkg::ST_NEW, 5'd1};
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %0d: %s got %0d want %0d", checked, what, got, want);
        errors++;
    endtask

    // Drive one request transfer per item, with a random gap before each
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy_q) begin
                i_start <= 1'b0;
                gap <= $urandom_range(0, 3);
            end else if (!i_start && req_pending.size() > 0) begin
                if (gap > 0) gap <= gap - 1;
                else begin
                    i_req <= req_pending[0];
                    i_start <= 1'b1;
                end
            end
        end
    end

    // Track acceptance at the rising edge and predict the verdict
    always @(posedge i_clk) begin
        o_busy_q <= o_busy;
        if (i_rst_n && i_start && !o_busy) begin
            verdicts_due.push_back(judge_request(req_pending.pop_front()));
            sent++;
        end
    end

    // Check each result strobe against the oldest prediction
    always @(posedge i_clk) begin
        pkswrl_pkg::t_res want;
        if (i_rst_n && o_done) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = verdicts_due.pop_front();
                if (o_res.allowed !== want.allowed)
                    report_mismatch("allowed", o_res.allowed, want.allowed);
                if (o_res.status !== want.status)
                    report_mismatch("status", o_res.status, want.status);
                if (o_res.attempts_in_window !== want.attempts_in_window)
                    report_mismatch("attempts", o_res.attempts_in_window,
                                    want.attempts_in_window);
            end
            checked++;
        end
    end

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == pkswrl_pkg::REG_MAX_ATTEMPTS) lim_max = val[4:0];
        else lim_win = val[15:0];
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Hold off until every queued transfer is sent and answered
    task automatic settle();
        while (req_pending.size() > 0 || i_start || verdicts_due.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic push(logic [31:0] a, logic [31:0] t);
        req_pending.push_back('{a, t});
    endtask

    // Random phase: a few hot keys on a clock that mostly creeps forward
    task automatic random_phase(int n, int nkeys, logic [31:0] base);
        logic [31:0] t;
        t = $urandom;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: t = t + $urandom_range(0, 70000);
                1: t = $urandom;
                default: t = t + $urandom_range(0, 12);
            endcase
            if ($urandom_range(0, 15) == 0) push($urandom, t);
            else push(base + $urandom_range(0, nkeys - 1), t);
        end
    endtask

    initial begin
        lim_max = pkswrl_pkg::MAX_ATTEMPTS_RESET;
        lim_win = pkswrl_pkg::WINDOW_RESET;
        key_cnt = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: limit reached, expiry, backwards time, wrap
        for (int i = 0; i < 11; i++) push(32'h0, 32'd100 + i);
        push(32'h0, 32'd200);
        push(32'hFFFF_FFFF, 32'hFFFF_FFF0);
        push(32'hFFFF_FFFF, 32'h0000_0010);
        push(32'hFFFF_FFFF, 32'h0000_0005);
        push(32'h0, 32'd150);
        settle();

        // Limit zero and window zero
        write_reg(pkswrl_pkg::REG_MAX_ATTEMPTS, 32'd0);
        write_reg(pkswrl_pkg::REG_WINDOW, 32'd0);
        push(32'h1234_5678, 32'd7);
        push(32'h1234_5678, 32'd7);
        push(32'h0, 32'd300);
        settle();

        // Limit above log depth, widest window
        write_reg(pkswrl_pkg::REG_MAX_ATTEMPTS, 32'd31);
        write_reg(pkswrl_pkg::REG_WINDOW, 32'd65535);
        for (int i = 0; i < 18; i++) push(32'hA5A5_0000, 32'd1000 + i);
        settle();

        write_reg(pkswrl_pkg::REG_MAX_ATTEMPTS, 32'd3);
        write_reg(pkswrl_pkg::REG_WINDOW, 32'd20);
        random_phase(300, 12, 32'h0A00_0000);
        settle();

        write_reg(pkswrl_pkg::REG_MAX_ATTEMPTS, 32'd16);
        write_reg(pkswrl_pkg::REG_WINDOW, 32'd1);
        random_phase(250, 10, 32'hC0A8_0000);
        settle();

        // Fill the table, then see unknown keys refused
        write_reg(pkswrl_pkg::REG_MAX_ATTEMPTS, 32'd1);
        write_reg(pkswrl_pkg::REG_WINDOW, 32'd40);
        for (int i = 0; i < 70; i++) push($urandom, 32'd5000 + i);
        random_phase(450, 20, 32'h0A00_0000);
        settle();

        $display("covered %0d requests, %0d results, %0d keys in table", sent, checked,
                 key_cnt);
        $display("limits 0/1/3/10/16/31, windows 0/1/20/40/60/65535, full table");
        if (errors == 0 && verdicts_due.size() == 0) begin
            $display("PASS per_key_sliding_window_rate_limiter");
        end else begin
            $display("FAIL per_key_sliding_window_rate_limiter");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL per_key_sliding_window_rate_limiter");
        $finish;
    end

endmodule

>>> per_key_sliding_window_rate_limiter.f
hdl/pkswrl_pkg.sv
hdl/pkswrl_ram.sv
hdl/per_key_sliding_window_rate_limiter.sv
dv/per_key_sliding_window_rate_limiter_tb.sv
